// ===== hw/rtl/ray_obb_slab_test_assert.svh =====
// assertion macros used by the ray box slab test rtl
`ifndef RAY_OBB_SLAB_TEST_ASSERT_SVH
`define RAY_OBB_SLAB_TEST_ASSERT_SVH

// same-cycle implication
`define ROST_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rost assertion failed");

// next-cycle implication
`define ROST_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rost assertion failed");

`endif

// ===== hw/rtl/rost_pkg.sv =====
// ----------------------------------------------------------------------------
// rost_pkg
// shared types and constants of the ray box slab test
// ----------------------------------------------------------------------------
`default_nettype none
package rost_pkg;
   localparam int EWidth  = 37;
   localparam int FWidth  = 22;
   localparam int NWidth  = 38;
   localparam int EpsQ16  = 66;

   localparam logic signed [31:0] TMax = 32'sh7fffffff;
   localparam logic signed [31:0] TMin = 32'sh80000000;
   localparam logic [30:0] FarLimitReset = 31'h7fffffff;
   localparam logic signed [17:0] DirXReset = 18'sd65536;

   typedef enum logic [2:0] {
      REG_ORIGIN_X = 3'd0,
      REG_ORIGIN_Y = 3'd1,
      REG_ORIGIN_Z = 3'd2,
      REG_DIR_X    = 3'd3,
      REG_DIR_Y    = 3'd4,
      REG_DIR_Z    = 3'd5,
      REG_FAR      = 3'd6,
      REG_NONE     = 3'd7
   } reg_index_type;

   typedef struct packed {
      logic signed [EWidth-1:0] e;
      logic signed [FWidth-1:0] f;
      logic signed [31:0]       lo;
      logic signed [31:0]       hi;
      logic                     last;
   } rost_entry_type;
endpackage
`default_nettype wire

// ===== hw/rtl/rost_front.sv =====
// ----------------------------------------------------------------------------
// rost_front
// takes box axis requests and forms the two dot products e and f
// ----------------------------------------------------------------------------
`default_nettype none
module rost_front import rost_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire logic [215:0]         req_tdata,
   input  wire logic                 req_tlast,
   input  wire logic signed [31:0]   origin_x,
   input  wire logic signed [31:0]   origin_y,
   input  wire logic signed [31:0]   origin_z,
   input  wire logic signed [17:0]   dir_x,
   input  wire logic signed [17:0]   dir_y,
   input  wire logic signed [17:0]   dir_z,
   output logic                      push_valid,
   input  wire logic                 push_ready,
   output rost_entry_type            push_entry
);
   typedef enum logic [1:0] {S_IDLE, S_MUL, S_PUSH} state_type;
   state_type state_ff;
   logic [1:0] cnt_ff;
   logic signed [17:0] ax_ff, ay_ff, az_ff;
   logic signed [32:0] dx_ff, dy_ff, dz_ff;
   logic signed [31:0] lo_ff, hi_ff;
   logic last_ff;
   logic signed [50:0] pe_ff, pe_in;
   logic signed [35:0] pf_ff, pf_in;
   logic signed [52:0] esum_ff;
   logic signed [37:0] fsum_ff;
   logic signed [17:0] a_sel, r_sel;
   logic signed [32:0] d_sel;

   assign req_tready = (state_ff == S_IDLE);
   assign push_valid = (state_ff == S_PUSH);
   assign push_entry.e    = esum_ff[52:16];
   assign push_entry.f    = fsum_ff[37:16];
   assign push_entry.lo   = lo_ff;
   assign push_entry.hi   = hi_ff;
   assign push_entry.last = last_ff;

   always_comb begin
      unique case (cnt_ff)
         2'd0: begin a_sel = ax_ff; d_sel = dx_ff; r_sel = dir_x; end
         2'd1: begin a_sel = ay_ff; d_sel = dy_ff; r_sel = dir_y; end
         default: begin a_sel = az_ff; d_sel = dz_ff; r_sel = dir_z; end
      endcase
      pe_in = a_sel * d_sel;
      pf_in = a_sel * r_sel;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= 2'd0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  ax_ff   <= req_tdata[17:0];
                  ay_ff   <= req_tdata[35:18];
                  az_ff   <= req_tdata[53:36];
                  dx_ff   <= {req_tdata[85], req_tdata[85:54]} - {origin_x[31], origin_x};
                  dy_ff   <= {req_tdata[117], req_tdata[117:86]} - {origin_y[31], origin_y};
                  dz_ff   <= {req_tdata[149], req_tdata[149:118]} - {origin_z[31], origin_z};
                  lo_ff   <= req_tdata[181:150];
                  hi_ff   <= req_tdata[213:182];
                  last_ff <= req_tlast;
                  esum_ff <= '0;
                  fsum_ff <= '0;
                  cnt_ff  <= 2'd0;
                  state_ff <= S_MUL;
               end
            end
            S_MUL: begin
               // product of one component per cycle, registered and then added to the sums
               pe_ff <= pe_in;
               pf_ff <= pf_in;
               if (cnt_ff != 2'd0) begin
                  esum_ff <= esum_ff + {{2{pe_ff[50]}}, pe_ff};
                  fsum_ff <= fsum_ff + {{2{pf_ff[35]}}, pf_ff};
               end
               cnt_ff <= cnt_ff + 2'd1;
               if (cnt_ff == 2'd3) state_ff <= S_PUSH;
            end
            S_PUSH: begin
               if (push_ready) state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

// ===== hw/rtl/rost_queue.sv =====
// ----------------------------------------------------------------------------
// rost_queue
// two-entry queue between the dot product front and the slab back end
// ----------------------------------------------------------------------------
`default_nettype none
module rost_queue import rost_pkg::*; (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           push_valid,
   output logic                push_ready,
   input  wire rost_entry_type push_entry,
   output logic                pop_valid,
   input  wire logic           pop,
   output rost_entry_type      pop_entry
);
   rost_entry_type mem_ff [2];
   logic wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;
   logic do_push, do_pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_entry  = mem_ff[rd_ptr_ff];
   assign do_push = push_valid && push_ready;
   assign do_pop  = pop && pop_valid;

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ptr_ff] <= push_entry;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (do_push) wr_ptr_ff <= ~wr_ptr_ff;
         if (do_pop) rd_ptr_ff <= ~rd_ptr_ff;
         if (do_push && !do_pop) count_ff <= count_ff + 2'd1;
         else if (do_pop && !do_push) count_ff <= count_ff - 2'd1;
      end
   end
endmodule
`default_nettype wire

// ===== hw/rtl/rost_div.sv =====
// ----------------------------------------------------------------------------
// rost_div
// bit-serial saturating divider, (num * 65536) / den truncated toward zero
// ----------------------------------------------------------------------------
`default_nettype none
module rost_div import rost_pkg::*; (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   input  wire logic signed [NWidth-1:0] num,
   input  wire logic signed [FWidth-1:0] den,
   output logic                          busy,
   output logic signed [31:0]            quot
);
   logic busy_ff, neg_ff, ovf_ff;
   logic [5:0] cnt_ff;
   logic [21:0] dm_ff, rem_ff;
   logic [32:0] low_ff;
   logic [37:0] num_mag;
   logic [21:0] den_mag;
   logic [53:0] dvd;
   logic [22:0] r2;
   logic qbit;

   always_comb begin
      num_mag = num[NWidth-1] ? 38'(-num) : 38'(num);
      den_mag = den[FWidth-1] ? 22'(-den) : 22'(den);
      dvd = {num_mag, 16'b0};
      r2 = {rem_ff, low_ff[32]};
      qbit = (r2 >= {1'b0, dm_ff});
      if (!ovf_ff) quot = 32'(low_ff);
      else quot = TMax;
      if (ovf_ff) quot = neg_ff ? TMin : TMax;
      else if (!neg_ff) quot = (low_ff > 33'h07fffffff) ? TMax : low_ff[31:0];
      else quot = (low_ff > 33'h080000000) ? TMin : 32'(-low_ff[31:0]);
   end

   assign busy = busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= 6'd0;
      end else if (start) begin
         neg_ff  <= num[NWidth-1] ^ den[FWidth-1];
         dm_ff   <= den_mag;
         ovf_ff  <= ({1'b0, dvd[53:33]} >= den_mag);
         rem_ff  <= {1'b0, dvd[53:33]};
         low_ff  <= dvd[32:0];
         cnt_ff  <= 6'd33;
         busy_ff <= 1'b1;
      end else if (busy_ff) begin
         rem_ff <= qbit ? 22'(r2 - {1'b0, dm_ff}) : r2[21:0];
         low_ff <= {low_ff[31:0], qbit};
         cnt_ff <= cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) busy_ff <= 1'b0;
      end
   end
endmodule
`default_nettype wire

// ===== hw/rtl/rost_back.sv =====
// ----------------------------------------------------------------------------
// rost_back
// slab update per axis and hit result per box
// ----------------------------------------------------------------------------
`default_nettype none
`include "ray_obb_slab_test_assert.svh"
module rost_back import rost_pkg::*; (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           pop_valid,
   output logic                pop,
   input  wire rost_entry_type pop_entry,
   input  wire logic [30:0]    far_limit,
   output logic                rsp_tvalid,
   input  wire logic           rsp_tready,
   output logic                rsp_hit
);
   typedef enum logic [1:0] {S_IDLE, S_DIV, S_UPDATE} state_type;
   state_type state_ff;
   logic signed [31:0] t_near_ff, t_far_ff;
   logic missed_ff, last_ff, rsp_valid_ff, hit_ff;
   logic out_free, parallel, slab_out, miss_now, rsp_set;
   logic signed [NWidth-1:0] e_ext, n_lo, n_hi, lo_ext, hi_ext;
   logic busy0, busy1, div_start;
   logic signed [31:0] q0, q1, t_lo, t_hi, nn, nf;

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_hit = hit_ff;

   always_comb begin
      e_ext  = {pop_entry.e[EWidth-1], pop_entry.e};
      lo_ext = {{(NWidth-32){pop_entry.lo[31]}}, pop_entry.lo};
      hi_ext = {{(NWidth-32){pop_entry.hi[31]}}, pop_entry.hi};
      n_lo = e_ext + lo_ext;
      n_hi = e_ext + hi_ext;
      parallel = (pop_entry.f <= FWidth'(EpsQ16)) && (pop_entry.f >= -FWidth'(EpsQ16));
      slab_out = ((lo_ext - e_ext) > 0) || ((hi_ext - e_ext) < 0);
      miss_now = missed_ff || (parallel && slab_out);
      pop = (state_ff == S_IDLE) && pop_valid && (!pop_entry.last || out_free);
      div_start = pop && !missed_ff && !parallel;
      // a box closes either straight from the queue or after its last division
      rsp_set = (pop && !div_start && pop_entry.last) ||
                ((state_ff == S_UPDATE) && last_ff && out_free);
      if (q0 > q1) begin t_lo = q1; t_hi = q0; end
      else begin t_lo = q0; t_hi = q1; end
      nf = (t_hi < t_far_ff) ? t_hi : t_far_ff;
      nn = (t_lo > t_near_ff) ? t_lo : t_near_ff;
   end

   rost_div u_div_lo (
      .clock(clock), .reset(reset), .start(div_start), .num(n_lo),
      .den(pop_entry.f), .busy(busy0), .quot(q0)
   );
   rost_div u_div_hi (
      .clock(clock), .reset(reset), .start(div_start), .num(n_hi),
      .den(pop_entry.f), .busy(busy1), .quot(q1)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         t_near_ff    <= '0;
         t_far_ff     <= {1'b0, FarLimitReset};
         missed_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         last_ff      <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_set || (rsp_valid_ff && !rsp_tready);
         unique case (state_ff)
            S_IDLE: begin
               if (div_start) begin
                  last_ff  <= pop_entry.last;
                  state_ff <= S_DIV;
               end else if (pop) begin
                  if (pop_entry.last) begin
                     hit_ff       <= !miss_now;
                     t_near_ff    <= '0;
                     t_far_ff     <= {1'b0, far_limit};
                     missed_ff    <= 1'b0;
                  end else begin
                     missed_ff <= miss_now;
                  end
               end
            end
            S_DIV: begin
               if (!busy0 && !busy1) state_ff <= S_UPDATE;
            end
            S_UPDATE: begin
               if (!last_ff) begin
                  t_near_ff <= nn;
                  t_far_ff  <= nf;
                  missed_ff <= (nf < nn);
                  state_ff  <= S_IDLE;
               end else if (out_free) begin
                  hit_ff       <= !(nf < nn);
                  t_near_ff    <= '0;
                  t_far_ff     <= {1'b0, far_limit};
                  missed_ff    <= 1'b0;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   `ROST_ASSERT_SAME(a_div_busy, clock, reset, state_ff == S_DIV, busy0 == busy1)
   `ROST_ASSERT_SAME(a_pop_idle, clock, reset, pop, state_ff == S_IDLE)
   `ROST_ASSERT_NEXT(a_box_restart, clock, reset, rsp_tvalid == 1'b0 && pop && !div_start && pop_entry.last, rsp_tvalid && !missed_ff && t_near_ff == 0)
endmodule
`default_nettype wire

// ===== hw/rtl/ray_obb_slab_test.sv =====
// ----------------------------------------------------------------------------
// ray_obb_slab_test
// slab test of one configured ray against oriented boxes, Q16.16
// ----------------------------------------------------------------------------
// Each request is one box axis; the request marked by tlast closes the box and
// yields one response whose bit 0 is the hit flag. A request passes through the
// dot product front and the back end, where, unless the box is already missed or
// the axis is near-parallel, the two bit-serial dividers run side by side (one
// quotient bit per cycle). A two-entry queue lets the front take the next axis
// while the back end divides.
// ----------------------------------------------------------------------------
`default_nettype none
module ray_obb_slab_test import rost_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // axis_x, axis_y, axis_z, center_x, center_y, center_z, slab_min, slab_max
   input  wire logic [215:0] req_tdata,
   input  wire logic         req_tlast,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // hit
   output logic [7:0]        rsp_tdata,
   input  wire logic         csr_psel,
   input  wire logic         csr_penable,
   input  wire logic         csr_pwrite,
   input  wire logic [4:0]   csr_paddr,
   input  wire logic [31:0]  csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);
   logic signed [31:0] origin_x_ff, origin_y_ff, origin_z_ff;
   logic signed [17:0] dir_x_ff, dir_y_ff, dir_z_ff;
   logic [30:0] far_limit_ff;
   reg_index_type idx;
   logic wr_en, push_valid, push_ready, pop_valid, pop, hit;
   rost_entry_type push_entry, pop_entry;

   assign csr_pready = 1'b1;
   assign idx = reg_index_type'(csr_paddr[4:2]);
   assign wr_en = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff  <= '0;
         origin_y_ff  <= '0;
         origin_z_ff  <= '0;
         dir_x_ff     <= DirXReset;
         dir_y_ff     <= '0;
         dir_z_ff     <= '0;
         far_limit_ff <= FarLimitReset;
      end else if (wr_en) begin
         unique case (idx)
            REG_ORIGIN_X: origin_x_ff  <= csr_pwdata;
            REG_ORIGIN_Y: origin_y_ff  <= csr_pwdata;
            REG_ORIGIN_Z: origin_z_ff  <= csr_pwdata;
            REG_DIR_X:    dir_x_ff     <= csr_pwdata[17:0];
            REG_DIR_Y:    dir_y_ff     <= csr_pwdata[17:0];
            REG_DIR_Z:    dir_z_ff     <= csr_pwdata[17:0];
            REG_FAR:      far_limit_ff <= csr_pwdata[30:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_ORIGIN_X: csr_prdata = origin_x_ff;
         REG_ORIGIN_Y: csr_prdata = origin_y_ff;
         REG_ORIGIN_Z: csr_prdata = origin_z_ff;
         REG_DIR_X:    csr_prdata = {{14{dir_x_ff[17]}}, dir_x_ff};
         REG_DIR_Y:    csr_prdata = {{14{dir_y_ff[17]}}, dir_y_ff};
         REG_DIR_Z:    csr_prdata = {{14{dir_z_ff[17]}}, dir_z_ff};
         REG_FAR:      csr_prdata = {1'b0, far_limit_ff};
         default:      csr_prdata = '0;
      endcase
   end

   rost_front u_front (
      .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .origin_x(origin_x_ff), .origin_y(origin_y_ff), .origin_z(origin_z_ff),
      .dir_x(dir_x_ff), .dir_y(dir_y_ff), .dir_z(dir_z_ff),
      .push_valid(push_valid), .push_ready(push_ready), .push_entry(push_entry)
   );

   rost_queue u_queue (
      .clock(clock), .reset(reset), .push_valid(push_valid), .push_ready(push_ready),
      .push_entry(push_entry), .pop_valid(pop_valid), .pop(pop), .pop_entry(pop_entry)
   );

   rost_back u_back (
      .clock(clock), .reset(reset), .pop_valid(pop_valid), .pop(pop),
      .pop_entry(pop_entry), .far_limit(far_limit_ff),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_hit(hit)
   );

   assign rsp_tdata = {7'b0, hit};
endmodule
`default_nettype wire
